>>> design/bmcp_pkg.sv
// ----------------------------------------------------------------------------
// bmcp_pkg
// Shared types and constants of the binary mask corridor points unit: the
// transaction payloads, the operation and register codes, and the default
// grid dimensions.
// ----------------------------------------------------------------------------
package bmcp_pkg;

	// Default storage dimensions and window limit.
	localparam int DEF_MAX_ROWS     = 64;
	localparam int DEF_MAX_COLS     = 64;
	localparam int DEF_MAX_CORRIDOR = 3;

	// Width of internal signed coordinate arithmetic (covers -3 .. 1023+).
	localparam int CRD_W = 12;

	// Item kinds.
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_EXPAND = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CORRIDOR_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE   = 2'd2;
	localparam int CFG_DATA_W = 7;

	// Register reset values.
	localparam logic [1:0] RST_CORRIDOR_SIZE = 2'd1;
	localparam logic [6:0] RST_ROWS_IN_USE   = 7'd64;
	localparam logic [6:0] RST_COLS_IN_USE   = 7'd64;

	typedef struct packed {
		logic       kind;
		logic [5:0] cell_row;
		logic [5:0] cell_col;
		logic       cell_bit;
	} item_t;

	typedef struct packed {
		logic [5:0] point_row;
		logic [5:0] point_col;
		logic       last_point;
	} point_t;

endpackage

>>> design/bmcp_ram.sv
// ----------------------------------------------------------------------------
// bmcp_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module bmcp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/binary_mask_corridor_points_unit.sv
// ----------------------------------------------------------------------------
// binary_mask_corridor_points_unit
// A write, or an expand of a cell outside the in-use region, is taken while
// idle. Any other expand then reads its own cell; a set cell is followed by a
// sweep of its (2*R+1)^2 window, the check of the last window cell and the
// hand-over of the final point, R being the capped corridor size.
// Throughput: one mask cell per cycle unless the output stalls; a new item is
// taken only once the previous expand is done. Reset: a clearing pass over all
// MAX_ROWS*MAX_COLS cells (4096 by default) zeroes the mask; items wait.
// ----------------------------------------------------------------------------
module binary_mask_corridor_points_unit
	import bmcp_pkg::*;
#(
	parameter int MAX_ROWS     = DEF_MAX_ROWS,
	parameter int MAX_COLS     = DEF_MAX_COLS,
	parameter int MAX_CORRIDOR = DEF_MAX_CORRIDOR
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Item channel.
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	// Point channel.
	output logic                  point_valid,
	input  logic                  point_ready,
	output point_t                point,
	// Configuration channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_CENTER = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	// Linear mask address of a cell: rows are laid out MAX_COLS cells apart.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [CRD_W-1:0] r,
			input logic [CRD_W-1:0] c);
		logic [31:0] lin;
		lin = 32'(r) * 32'(MAX_COLS) + 32'(c);
		return lin[ADDR_W-1:0];
	endfunction

	state_t state_q;

	// Configuration registers.
	logic [1:0] corridor_q;
	logic [6:0] rows_q;
	logic [6:0] cols_q;

	// Clearing pass address.
	logic [ADDR_W-1:0] clr_q;

	// Expand item context and window issue pointer.
	logic [5:0] row_q;
	logic [5:0] col_q;
	logic [2:0] win_i_q;
	logic [2:0] win_j_q;
	logic       issue_q;

	// Stage 1 of the window scan: the position whose mask bit is on rdata.
	logic             valid_s1;
	logic             inb_s1;
	logic [CRD_W-1:0] r_s1;
	logic [CRD_W-1:0] c_s1;

	// Point held back until it is known whether another one follows it.
	logic [5:0] pend_row_q;
	logic [5:0] pend_col_q;

	// Output register.
	logic   point_valid_q;
	point_t point_q;

	// RAM ports.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic              ram_rdata;

	// Effective limits.
	logic [CRD_W-1:0] nrows;
	logic [CRD_W-1:0] ncols;
	logic [1:0]       rad;
	logic [2:0]       span;

	// Window position being issued.
	logic [CRD_W-1:0] win_r;
	logic [CRD_W-1:0] win_c;
	logic             win_inb;

	// Input item decode.
	logic [CRD_W-1:0] in_r;
	logic [CRD_W-1:0] in_c;
	logic             in_storage;
	logic             in_region;
	logic             item_fire;

	// Scan control.
	logic out_free;
	logic hit_s1;
	logic stall;
	logic emit_mid;
	logic emit_last;

	bmcp_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_mask (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The in-use limits are capped at the storage size; the corridor at its
	// maximum. The user must not change configuration while an item is in flight;
	// the block does not enforce this; these are used directly, not captured per item.
	always_comb begin
		nrows = (CRD_W'(rows_q) > CRD_W'(MAX_ROWS)) ? CRD_W'(MAX_ROWS) : CRD_W'(rows_q);
		ncols = (CRD_W'(cols_q) > CRD_W'(MAX_COLS)) ? CRD_W'(MAX_COLS) : CRD_W'(cols_q);
		rad   = (corridor_q > 2'(MAX_CORRIDOR)) ? 2'(MAX_CORRIDOR) : corridor_q;
		span  = {rad, 1'b0};
	end

	// Window coordinates: the top bit marks a position above or left of the
	// grid, which wraps negative in this arithmetic.
	always_comb begin
		win_r   = CRD_W'(row_q) + CRD_W'(win_i_q) - CRD_W'(rad);
		win_c   = CRD_W'(col_q) + CRD_W'(win_j_q) - CRD_W'(rad);
		win_inb = !win_r[CRD_W-1] && !win_c[CRD_W-1] && (win_r < nrows) && (win_c < ncols);
	end

	always_comb begin
		in_r       = CRD_W'(item.cell_row);
		in_c       = CRD_W'(item.cell_col);
		in_storage = (in_r < CRD_W'(MAX_ROWS)) && (in_c < CRD_W'(MAX_COLS));
		in_region  = (in_r < nrows) && (in_c < ncols);
		item_ready = (state_q == ST_IDLE);
		item_fire  = item_valid && item_ready;
	end

	// A window cell that reads 0 produces a point; it can only be taken when
	// the output register is free, otherwise the scan holds. A hit pushes the
	// held point out as a non-final one; the flush hands over the final one.
	always_comb begin
		out_free  = !point_valid_q || point_ready;
		hit_s1    = (state_q == ST_SCAN) && valid_s1 && inb_s1 && !ram_rdata;
		stall     = hit_s1 && !out_free;
		emit_mid  = hit_s1 && out_free;
		emit_last = (state_q == ST_FLUSH) && out_free;
	end

	// RAM access. Reads are only issued when the data will be consumed, so a
	// stalled scan keeps its read data on the RAM output.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				if (item_fire && item.kind == KIND_WRITE && in_storage) begin
					ram_we    = 1'b1;
					ram_waddr = cell_addr(in_r, in_c);
					ram_wdata = item.cell_bit;
				end
				if (item_fire && item.kind == KIND_EXPAND && in_region) begin
					ram_re    = 1'b1;
					ram_raddr = cell_addr(in_r, in_c);
				end
			end
			ST_SCAN: begin
				if (issue_q && !stall && win_inb) begin
					ram_re    = 1'b1;
					ram_raddr = cell_addr(win_r, win_c);
				end
			end
			ST_CENTER, ST_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	// Configuration port: always ready; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corridor_q <= RST_CORRIDOR_SIZE;
			rows_q     <= RST_ROWS_IN_USE;
			cols_q     <= RST_COLS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CORRIDOR_SIZE: corridor_q <= cfg_data[1:0];
				CFG_ROWS_IN_USE:   rows_q     <= cfg_data;
				CFG_COLS_IN_USE:   cols_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer. The expand flow is: read the named cell and, if set, sweep the
	// window one cell per cycle in row-major order, holding while the output
	// stalls. Each new point pushes the held point out as a non-final one; the
	// point still held when the sweep ends leaves last, flagged as final.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			issue_q       <= 1'b0;
			valid_s1      <= 1'b0;
			win_i_q       <= '0;
			win_j_q       <= '0;
			point_valid_q <= 1'b0;
		end else begin
			if (emit_mid || emit_last) begin
				point_valid_q <= 1'b1;
			end else if (point_valid_q && point_ready) begin
				point_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_fire && item.kind == KIND_EXPAND && in_region) begin
						state_q <= ST_CENTER;
					end
				end
				ST_CENTER: begin
					if (ram_rdata) begin
						state_q  <= ST_SCAN;
						issue_q  <= 1'b1;
						valid_s1 <= 1'b0;
						win_i_q  <= '0;
						win_j_q  <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						valid_s1 <= issue_q;
						if (issue_q) begin
							if (win_j_q == span) begin
								win_j_q <= '0;
								if (win_i_q == span) begin
									issue_q <= 1'b0;
								end else begin
									win_i_q <= win_i_q + 1'b1;
								end
							end else begin
								win_j_q <= win_j_q + 1'b1;
							end
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: item context, stage 1 coordinates, held point and
	// the output point.
	always_ff @(posedge clk) begin
		if (item_fire) begin
			row_q <= item.cell_row;
			col_q <= item.cell_col;
		end
		if (state_q == ST_SCAN && !stall) begin
			inb_s1 <= win_inb;
			r_s1   <= win_r;
			c_s1   <= win_c;
		end
		if (emit_mid || emit_last) begin
			point_q <= '{point_row: pend_row_q, point_col: pend_col_q,
					last_point: emit_last};
		end
		if (state_q == ST_CENTER) begin
			pend_row_q <= row_q;
			pend_col_q <= col_q;
		end else if (emit_mid) begin
			pend_row_q <= r_s1[5:0];
			pend_col_q <= c_s1[5:0];
		end
	end

	assign point_valid = point_valid_q;
	assign point       = point_q;

endmodule
